[hw/rtl/keyed_handle_pool_lru_macros.svh]
// ----------------------------------------------------------------------------
// keyed_handle_pool_lru_macros.svh - assertion macros
// Shared assertion helpers; expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef KEYED_HANDLE_POOL_LRU_MACROS_SVH
`define KEYED_HANDLE_POOL_LRU_MACROS_SVH

// property must hold on every clock outside reset
`define KHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define KHP_NEVER(lbl, expr, msg) \
  `KHP_ASSERT(lbl, !(expr), msg)

`endif

[hw/rtl/khp_pkg.sv]
// ----------------------------------------------------------------------------
// khp_pkg - handle pool package
// Sizes, codes and the slot record of the keyed handle pool.
// ----------------------------------------------------------------------------
`default_nettype none

package khp_pkg;

  localparam int unsigned PoolSlots = 32;
  localparam int unsigned IdxW      = (PoolSlots > 1) ? $clog2(PoolSlots) : 1;
  localparam int unsigned CntW      = $clog2(PoolSlots + 1);
  localparam int unsigned CloseCntW = 7;

  typedef enum logic [1:0] {
    KIND_CHECKOUT = 2'd0,
    KIND_CHECKIN  = 2'd1,
    KIND_SWEEP    = 2'd2,
    KIND_NOP      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_e;

  localparam logic signed [12:0] NoHandle = -13'sd1;

  typedef struct packed {
    logic [11:0] handle;
    logic [15:0] port;
    logic [31:0] host;
    logic [31:0] stamp;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

`default_nettype wire

[hw/rtl/khp_req_if.sv]
// ----------------------------------------------------------------------------
// khp_req_if - request channel
// Valid/ready channel carrying one pool request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface khp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        host_tag;
  logic [15:0]        port;
  logic signed [12:0] handle;
  logic [31:0]        cur_time;
  logic [30:0]        max_idle;

  modport source (
    output valid, kind, host_tag, port, handle, cur_time, max_idle,
    input  ready
  );
  modport sink (
    input  valid, kind, host_tag, port, handle, cur_time, max_idle,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/khp_rsp_if.sv]
// ----------------------------------------------------------------------------
// khp_rsp_if - response channel
// Valid/ready channel carrying one pool result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface khp_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [12:0] out_handle;
  logic               close_valid;
  logic [11:0]        close_handle;
  logic [6:0]         closed_count;
  logic               last;
  logic [31:0]        checkout_count;
  logic [31:0]        checkin_count;
  logic [31:0]        hit_count;
  logic [31:0]        miss_count;

  modport source (
    output valid, status, out_handle, close_valid, close_handle, closed_count, last,
           checkout_count, checkin_count, hit_count, miss_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, close_valid, close_handle, closed_count, last,
           checkout_count, checkin_count, hit_count, miss_count,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/khp_ram.sv]
// ----------------------------------------------------------------------------
// khp_ram - slot storage
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module khp_ram #(
  parameter  int unsigned Depth = 32,
  parameter  int unsigned Width = 92,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/keyed_handle_pool_lru.sv]
// ----------------------------------------------------------------------------
// keyed_handle_pool_lru - keyed idle connection handle pool
// Keyed handle table with checkout, checkin with oldest-stamp eviction,
// and idle sweep, scanned one slot per cycle while rsp_o does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one request word (checkout, checkin or sweep) when the block
//   is idle; ready is low while a request is being worked on.
//   rsp_o returns result words through an output register; last marks the
//   final word of a request. Sweep gives one word per removed handle, or one
//   when none is removed; the other kinds give exactly one.
//   Every slot is read through the single slot RAM read port, one per cycle
//   while rsp_o does not stall; a checkout hit ends the scan at the matching
//   slot. A rejected checkin or an unused kind skips the scan.
//   The next request is taken while the last result still waits in the
//   output register.
//   When rsp_o stalls, the scan halts at the next word to emit and resumes
//   when it is taken.
//   Reset empties the table and clears all four counters; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_handle_pool_lru_macros.svh"

module keyed_handle_pool_lru (
  input  logic      clk_i,
  input  logic      rst_ni,
  khp_req_if.sink   req_i,
  khp_rsp_if.source rsp_o
);
  import khp_pkg::*;

  state_e state_q, state_d;
  kind_e  op_q, op_d;
  logic   reject_q, reject_d;

  logic [31:0]        host_q, host_d;
  logic [15:0]        port_q, port_d;
  logic [11:0]        handle_q, handle_d;
  logic [31:0]        now_q, now_d;
  logic signed [32:0] cutoff_q, cutoff_d;

  logic [PoolSlots-1:0] vld_q, vld_d;

  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            cmp_v_q, cmp_v_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;

  logic            empty_v_q, empty_v_d;
  logic [IdxW-1:0] empty_idx_q, empty_idx_d;
  logic            old_v_q, old_v_d;
  logic [IdxW-1:0] old_idx_q, old_idx_d;
  logic [31:0]     old_time_q, old_time_d;
  logic [11:0]     old_handle_q, old_handle_d;

  logic            swp_v_q, swp_v_d;
  logic [11:0]     swp_handle_q, swp_handle_d;
  logic [CntW-1:0] swp_cnt_q, swp_cnt_d;

  logic [31:0] co_q, co_d, ci_q, ci_d, hit_q, hit_d, miss_q, miss_d;

  logic               ov_q, ov_d;
  status_e            o_status_q;
  logic signed [12:0] o_handle_q;
  logic               o_cv_q;
  logic [11:0]        o_ch_q;
  logic [6:0]         o_cc_q;
  logic               o_last_q;
  logic [31:0]        o_co_q, o_ci_q, o_hit_q, o_miss_q;

  logic               emit;
  status_e            e_status;
  logic signed [12:0] e_handle;
  logic               e_cv;
  logic [11:0]        e_ch;
  logic [6:0]         e_cc;
  logic               e_last;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  slot_t           ram_wdata, rdata;

  logic in_fire, out_free, cmp_live, co_hit, swp_hit, stall;
  logic [IdxW-1:0] target;

  khp_ram #(
    .Depth (PoolSlots),
    .Width (SlotW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || rsp_o.ready;

  assign cmp_live = vld_q[cmp_idx_q];
  assign co_hit   = cmp_v_q && (op_q == KIND_CHECKOUT) && cmp_live &&
                    (rdata.port == port_q) && (rdata.host == host_q);
  assign swp_hit  = cmp_v_q && (op_q == KIND_SWEEP) && cmp_live &&
                    ($signed({1'b0, rdata.stamp}) < cutoff_q);
  assign stall    = !out_free && (co_hit || (swp_hit && swp_v_q));
  assign target   = empty_v_q ? empty_idx_q : old_idx_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    reject_d     = reject_q;
    host_d       = host_q;
    port_d       = port_q;
    handle_d     = handle_q;
    now_d        = now_q;
    cutoff_d     = cutoff_q;
    vld_d        = vld_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    empty_v_d    = empty_v_q;
    empty_idx_d  = empty_idx_q;
    old_v_d      = old_v_q;
    old_idx_d    = old_idx_q;
    old_time_d   = old_time_q;
    old_handle_d = old_handle_q;
    swp_v_d      = swp_v_q;
    swp_handle_d = swp_handle_q;
    swp_cnt_d    = swp_cnt_q;
    co_d         = co_q;
    ci_d         = ci_q;
    hit_d        = hit_q;
    miss_d       = miss_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = target;
    ram_raddr    = rd_cnt_q[IdxW-1:0];
    ram_wdata    = '{handle: handle_q, port: port_q, host: host_q, stamp: now_q};
    emit         = 1'b0;
    e_status     = STAT_OK;
    e_handle     = NoHandle;
    e_cv         = 1'b0;
    e_ch         = '0;
    e_cc         = '0;
    e_last       = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d      = kind_e'(req_i.kind);
          reject_d  = req_i.handle[12];
          host_d    = req_i.host_tag;
          port_d    = req_i.port;
          handle_d  = req_i.handle[11:0];
          now_d     = req_i.cur_time;
          cutoff_d  = $signed({1'b0, req_i.cur_time}) - $signed({2'b00, req_i.max_idle});
          rd_cnt_d  = '0;
          cmp_v_d   = 1'b0;
          empty_v_d = 1'b0;
          old_v_d   = 1'b0;
          swp_v_d   = 1'b0;
          swp_cnt_d = '0;
          if (req_i.kind == KIND_CHECKOUT || req_i.kind == KIND_SWEEP ||
              (req_i.kind == KIND_CHECKIN && !req_i.handle[12])) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (rd_cnt_q < CntW'(PoolSlots)) begin
            ram_re    = 1'b1;
            rd_cnt_d  = rd_cnt_q + CntW'(1);
            cmp_v_d   = 1'b1;
            cmp_idx_d = rd_cnt_q[IdxW-1:0];
          end else begin
            cmp_v_d = 1'b0;
          end

          if (cmp_v_q) begin
            case (op_q)
              KIND_CHECKOUT: begin
                if (co_hit) begin
                  vld_d[cmp_idx_q] = 1'b0;
                  co_d     = co_q + 32'd1;
                  hit_d    = hit_q + 32'd1;
                  emit     = 1'b1;
                  e_handle = $signed({1'b0, rdata.handle});
                  cmp_v_d  = 1'b0;
                  state_d  = S_IDLE;
                end
              end
              KIND_CHECKIN: begin
                if (!cmp_live && !empty_v_q) begin
                  empty_v_d   = 1'b1;
                  empty_idx_d = cmp_idx_q;
                end
                if (!old_v_q || (rdata.stamp < old_time_q)) begin
                  old_v_d      = 1'b1;
                  old_idx_d    = cmp_idx_q;
                  old_time_d   = rdata.stamp;
                  old_handle_d = rdata.handle;
                end
              end
              KIND_SWEEP: begin
                if (swp_hit) begin
                  vld_d[cmp_idx_q] = 1'b0;
                  if (swp_v_q) begin
                    emit   = 1'b1;
                    e_cv   = 1'b1;
                    e_ch   = swp_handle_q;
                    e_cc   = CloseCntW'(swp_cnt_q);
                    e_last = 1'b0;
                  end
                  swp_v_d      = 1'b1;
                  swp_handle_d = rdata.handle;
                  swp_cnt_d    = swp_cnt_q + CntW'(1);
                end
              end
              default: begin
              end
            endcase
          end else if (rd_cnt_q == CntW'(PoolSlots)) begin
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (op_q)
            KIND_CHECKOUT: begin
              co_d     = co_q + 32'd1;
              miss_d   = miss_q + 32'd1;
              e_status = STAT_MISS;
            end
            KIND_CHECKIN: begin
              if (reject_q) begin
                e_status = STAT_REJECT;
              end else begin
                ram_we        = 1'b1;
                vld_d[target] = 1'b1;
                ci_d          = ci_q + 32'd1;
                e_cv          = !empty_v_q;
                e_ch          = empty_v_q ? 12'd0 : old_handle_q;
              end
            end
            KIND_SWEEP: begin
              if (swp_v_q) begin
                e_cv = 1'b1;
                e_ch = swp_handle_q;
                e_cc = CloseCntW'(swp_cnt_q);
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      ov_d = 1'b1;
    end else if (rsp_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      rd_cnt_q  <= '0;
      cmp_v_q   <= 1'b0;
      empty_v_q <= 1'b0;
      old_v_q   <= 1'b0;
      swp_v_q   <= 1'b0;
      swp_cnt_q <= '0;
      co_q      <= '0;
      ci_q      <= '0;
      hit_q     <= '0;
      miss_q    <= '0;
      ov_q      <= 1'b0;
      op_q      <= KIND_NOP;
      reject_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_v_q   <= cmp_v_d;
      empty_v_q <= empty_v_d;
      old_v_q   <= old_v_d;
      swp_v_q   <= swp_v_d;
      swp_cnt_q <= swp_cnt_d;
      co_q      <= co_d;
      ci_q      <= ci_d;
      hit_q     <= hit_d;
      miss_q    <= miss_d;
      ov_q      <= ov_d;
      op_q      <= op_d;
      reject_q  <= reject_d;
    end
  end

  always_ff @(posedge clk_i) begin
    host_q       <= host_d;
    port_q       <= port_d;
    handle_q     <= handle_d;
    now_q        <= now_d;
    cutoff_q     <= cutoff_d;
    cmp_idx_q    <= cmp_idx_d;
    empty_idx_q  <= empty_idx_d;
    old_idx_q    <= old_idx_d;
    old_time_q   <= old_time_d;
    old_handle_q <= old_handle_d;
    swp_handle_q <= swp_handle_d;
    if (emit) begin
      o_status_q <= e_status;
      o_handle_q <= e_handle;
      o_cv_q     <= e_cv;
      o_ch_q     <= e_ch;
      o_cc_q     <= e_cc;
      o_last_q   <= e_last;
      o_co_q     <= co_d;
      o_ci_q     <= ci_d;
      o_hit_q    <= hit_d;
      o_miss_q   <= miss_d;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.status         = o_status_q;
  assign rsp_o.out_handle     = o_handle_q;
  assign rsp_o.close_valid    = o_cv_q;
  assign rsp_o.close_handle   = o_ch_q;
  assign rsp_o.closed_count   = o_cc_q;
  assign rsp_o.last           = o_last_q;
  assign rsp_o.checkout_count = o_co_q;
  assign rsp_o.checkin_count  = o_ci_q;
  assign rsp_o.hit_count      = o_hit_q;
  assign rsp_o.miss_count     = o_miss_q;

  `KHP_ASSERT(a_co_balance, co_q == hit_q + miss_q, "checkout count differs from hits plus misses")

  `KHP_ASSERT(a_evict_full,
    (state_q == S_FINISH && op_q == KIND_CHECKIN && !reject_q && !empty_v_q) |-> &vld_q,
    "eviction chosen while an empty slot exists")

  `KHP_ASSERT(a_fill_grows,
    (state_q == S_FINISH && op_q == KIND_CHECKIN && !reject_q && empty_v_q && out_free)
      |=> ($countones(vld_q) == $past($countones(vld_q)) + 1),
    "checkin into empty slot did not add one entry")

  `KHP_NEVER(a_swp_bound, swp_cnt_q > CntW'(PoolSlots), "sweep removed more than the table holds")

  `KHP_NEVER(a_fail_close,
    rsp_o.valid && rsp_o.status != STAT_OK && rsp_o.close_valid,
    "miss or reject reports a closed handle")

endmodule

`default_nettype wire

[tb/khp_pool_checker.sv]
// ----------------------------------------------------------------------------
// khp_pool_checker - handle pool scoreboard
// Watches the request and result channels of the keyed handle pool, keeps
// its own copy of the slot table and counters, predicts every result word
// of each accepted request and compares the words in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module khp_pool_checker (
  input  logic clk_i,
  input  logic rst_ni,
  khp_req_if   req_mon,
  khp_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import khp_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] out_handle;
    logic        close_valid;
    logic [11:0] close_handle;
    logic [6:0]  closed_count;
    logic        last;
    logic [31:0] checkout_count;
    logic [31:0] checkin_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } pool_rsp_t;

  logic        slot_used [PoolSlots];
  slot_t       slot_rec  [PoolSlots];
  logic [31:0] checkouts_seen;
  logic [31:0] checkins_seen;
  logic [31:0] hits_seen;
  logic [31:0] misses_seen;
  pool_rsp_t   expected_rsp_q [$];
  pool_rsp_t   oldest_rsp;
  int          n_fail    = 0;
  int          n_checked = 0;
  int          n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;
  assign checked_o    = n_checked;

  task automatic queue_word(input logic [1:0] status, input logic [12:0] out_handle,
                            input logic close_valid, input logic [11:0] close_handle,
                            input logic [6:0] closed_count, input logic last);
    pool_rsp_t w;
    w.status         = status;
    w.out_handle     = out_handle;
    w.close_valid    = close_valid;
    w.close_handle   = close_handle;
    w.closed_count   = closed_count;
    w.last           = last;
    w.checkout_count = checkouts_seen;
    w.checkin_count  = checkins_seen;
    w.hit_count      = hits_seen;
    w.miss_count     = misses_seen;
    expected_rsp_q.push_back(w);
  endtask

  task automatic predict_pool_op();
    int                 hit_idx;
    int                 put_idx;
    int                 n_stale;
    int                 n_removed;
    logic               evicted;
    logic [11:0]        ev_handle;
    logic signed [33:0] cutoff;
    hit_idx   = -1;
    put_idx   = -1;
    n_stale   = 0;
    n_removed = 0;
    evicted   = 1'b0;
    ev_handle = '0;
    cutoff    = $signed({2'b00, req_mon.cur_time}) - $signed({3'b000, req_mon.max_idle});
    case (kind_e'(req_mon.kind))
      KIND_CHECKOUT: begin
        checkouts_seen += 1;
        for (int i = 0; i < PoolSlots; i++) begin
          if (hit_idx < 0 && slot_used[i] && slot_rec[i].port == req_mon.port &&
              slot_rec[i].host == req_mon.host_tag) begin
            hit_idx = i;
          end
        end
        if (hit_idx >= 0) begin
          slot_used[hit_idx] = 1'b0;
          hits_seen += 1;
          queue_word(STAT_OK, {1'b0, slot_rec[hit_idx].handle}, 1'b0, '0, '0, 1'b1);
        end else begin
          misses_seen += 1;
          queue_word(STAT_MISS, NoHandle, 1'b0, '0, '0, 1'b1);
        end
      end
      KIND_CHECKIN: begin
        if (req_mon.handle[12]) begin
          queue_word(STAT_REJECT, NoHandle, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < PoolSlots; i++) begin
            if (put_idx < 0 && !slot_used[i]) put_idx = i;
          end
          if (put_idx < 0) begin
            put_idx = 0;
            for (int i = 1; i < PoolSlots; i++) begin
              if (slot_rec[i].stamp < slot_rec[put_idx].stamp) put_idx = i;
            end
            evicted   = 1'b1;
            ev_handle = slot_rec[put_idx].handle;
          end
          slot_used[put_idx] = 1'b1;
          slot_rec[put_idx]  = '{handle: req_mon.handle[11:0], port: req_mon.port,
                                 host: req_mon.host_tag, stamp: req_mon.cur_time};
          checkins_seen += 1;
          queue_word(STAT_OK, NoHandle, evicted, ev_handle, '0, 1'b1);
        end
      end
      KIND_SWEEP: begin
        for (int i = 0; i < PoolSlots; i++) begin
          if (slot_used[i] && $signed({2'b00, slot_rec[i].stamp}) < cutoff) n_stale++;
        end
        for (int i = 0; i < PoolSlots; i++) begin
          if (slot_used[i] && $signed({2'b00, slot_rec[i].stamp}) < cutoff) begin
            slot_used[i] = 1'b0;
            n_removed++;
            queue_word(STAT_OK, NoHandle, 1'b1, slot_rec[i].handle, 7'(n_removed),
                       n_removed == n_stale);
          end
        end
        if (n_stale == 0) queue_word(STAT_OK, NoHandle, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        queue_word(STAT_OK, NoHandle, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PoolSlots; i++) begin
        slot_used[i] = 1'b0;
        slot_rec[i]  = '0;
      end
      checkouts_seen = '0;
      checkins_seen  = '0;
      hits_seen      = '0;
      misses_seen    = '0;
      expected_rsp_q.delete();
      n_pending = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result word with no request outstanding");
          n_fail++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          check_field("status", 32'(oldest_rsp.status), 32'(rsp_mon.status));
          check_field("out_handle", {19'b0, oldest_rsp.out_handle}, {19'b0, rsp_mon.out_handle});
          check_field("close_valid", 32'(oldest_rsp.close_valid), 32'(rsp_mon.close_valid));
          check_field("close_handle", 32'(oldest_rsp.close_handle), 32'(rsp_mon.close_handle));
          check_field("closed_count", 32'(oldest_rsp.closed_count), 32'(rsp_mon.closed_count));
          check_field("last", 32'(oldest_rsp.last), 32'(rsp_mon.last));
          check_field("checkout_count", oldest_rsp.checkout_count, rsp_mon.checkout_count);
          check_field("checkin_count", oldest_rsp.checkin_count, rsp_mon.checkin_count);
          check_field("hit_count", oldest_rsp.hit_count, rsp_mon.hit_count);
          check_field("miss_count", oldest_rsp.miss_count, rsp_mon.miss_count);
          n_checked++;
        end
      end
      if (req_mon.valid && req_mon.ready) predict_pool_op();
      n_pending = expected_rsp_q.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_keyed_handle_pool_lru.sv]
// ----------------------------------------------------------------------------
// tb_keyed_handle_pool_lru - handle pool testbench
// Drives directed and random checkout, checkin and sweep words into the
// pool under three stall profiles and lets the checker score every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyed_handle_pool_lru;
  import khp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 80;
  localparam int RandomWords = 260;
  localparam int KeyCount    = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 61;
  int          fail_count;
  int          pending;
  int          checked;
  int          sent_words = 0;
  logic [31:0] clock_secs;
  logic [31:0] host_pool [KeyCount];
  logic [15:0] port_pool [KeyCount];

  khp_req_if req_if ();
  khp_rsp_if rsp_if ();

  keyed_handle_pool_lru i_dut (
    .clk_i,
    .rst_ni,
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  khp_pool_checker i_checker (
    .clk_i,
    .rst_ni,
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input kind_e kind, input logic [31:0] host, input logic [15:0] port,
                           input logic signed [12:0] handle, input logic [31:0] now,
                           input logic [30:0] idle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.host_tag <= host;
    req_if.port     <= port;
    req_if.handle   <= handle;
    req_if.cur_time <= now;
    req_if.max_idle <= idle;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_words++;
  endtask

  task automatic run_random_phase(input int n_words);
    int          done;
    int          pick;
    int          k;
    int          r;
    logic [30:0] idle;
    done = 0;
    while (done < n_words) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // burst of checkins fills the table and forces evictions
        repeat ($urandom_range(20, 40)) begin
          if (done >= n_words) break;
          k = $urandom_range(0, KeyCount - 1);
          clock_secs += $urandom_range(0, 3);
          send_word(KIND_CHECKIN, host_pool[k], port_pool[k], $signed({1'b0, 12'($urandom)}),
                    clock_secs, 31'($urandom));
          done++;
        end
      end else if (pick < 8) begin
        repeat (12) begin
          if (done >= n_words) break;
          k = $urandom_range(0, KeyCount - 1);
          r = $urandom_range(0, 99);
          clock_secs += $urandom_range(0, 2);
          if (r < 45) begin
            send_word(KIND_CHECKOUT, host_pool[k], port_pool[k], 13'($urandom), clock_secs,
                      31'($urandom));
          end else if (r < 80) begin
            send_word(KIND_CHECKIN, host_pool[k], port_pool[k], $signed({1'b0, 12'($urandom)}),
                      clock_secs, 31'($urandom));
          end else if (r < 88) begin
            send_word(KIND_CHECKOUT, $urandom, 16'($urandom), 13'($urandom), clock_secs,
                      31'($urandom));
          end else if (r < 94) begin
            send_word(KIND_CHECKIN, host_pool[k], port_pool[k], $signed({1'b1, 12'($urandom)}),
                      clock_secs, 31'($urandom));
          end else begin
            send_word(KIND_NOP, $urandom, 16'($urandom), 13'($urandom), $urandom,
                      31'($urandom));
          end
          done++;
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r < 8) idle = 31'($urandom_range(0, 80));
        else if (r == 8) idle = 31'($urandom);
        else idle = '1;
        send_word(KIND_SWEEP, $urandom, 16'($urandom), 13'($urandom), clock_secs, idle);
        done++;
      end
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.kind     <= KIND_CHECKOUT;
    req_if.host_tag <= '0;
    req_if.port     <= '0;
    req_if.handle   <= '0;
    req_if.cur_time <= '0;
    req_if.max_idle <= '0;
    for (int i = 0; i < KeyCount; i++) begin
      host_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    host_pool[0] = '1;
    port_pool[0] = '1;
    host_pool[1] = '0;
    port_pool[1] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, key extremes, rejects, partial key, sweep cutoffs
    send_word(KIND_CHECKOUT, 32'h0, 16'h0, 13'sd0, 32'd0, 31'd0);
    send_word(KIND_CHECKIN, 32'h0, 16'h0, 13'sd0, 32'd0, 31'd0);
    send_word(KIND_CHECKIN, '1, '1, 13'sd4095, '1, '1);
    send_word(KIND_CHECKIN, 32'h1234_5678, 16'h4321, -13'sd1, 32'd3, 31'd0);
    send_word(KIND_CHECKIN, 32'h1234_5678, 16'h4321, -13'sd4096, 32'd3, 31'd0);
    send_word(KIND_NOP, '1, '1, -13'sd1, '1, '1);
    send_word(KIND_CHECKIN, 32'h5555_5555, 16'hAAAA, 13'sh555, 32'd100, 31'd0);
    send_word(KIND_CHECKIN, 32'h5555_5555, 16'hAAAA, 13'shAAA, 32'd100, 31'd0);
    send_word(KIND_CHECKOUT, 32'h5555_5555, 16'hAAAA, 13'sd0, 32'd100, 31'd0);
    send_word(KIND_CHECKOUT, '1, 16'h0, 13'sd0, 32'd100, 31'd0);
    send_word(KIND_CHECKOUT, 32'h0, '1, 13'sd0, 32'd100, 31'd0);
    send_word(KIND_CHECKOUT, '1, '1, 13'sd0, 32'd100, 31'd0);
    send_word(KIND_SWEEP, 32'h0, 16'h0, 13'sd0, 32'd5, 31'd10);
    send_word(KIND_SWEEP, 32'h0, 16'h0, 13'sd0, 32'd100, 31'd0);
    send_word(KIND_SWEEP, '1, '1, 13'sd0, '1, 31'd0);
    send_word(KIND_SWEEP, 32'h0, 16'h0, 13'sd0, 32'd0, 31'd0);
    send_word(KIND_CHECKIN, 32'h1, 16'h1, 13'sd1, 32'd7, 31'd0);
    send_word(KIND_CHECKIN, 32'h2, 16'h2, 13'sd2, 32'd7, 31'd0);
    send_word(KIND_SWEEP, 32'h0, 16'h0, 13'sd0, 32'd0, '1);
    send_word(KIND_SWEEP, 32'h0, 16'h0, 13'sd0, 32'd8, 31'd0);
    send_word(KIND_NOP, 32'h0, 16'h0, 13'sd0, 32'd0, 31'd0);

    clock_secs = 32'd1000;
    run_random_phase(RandomWords / 3);
    send_idle_pct = 61;
    recv_idle_pct = 31;
    clock_secs    = 32'hFFFF_FF00;
    run_random_phase(RandomWords / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clock_secs    = $urandom;
    run_random_phase(RandomWords - 2 * (RandomWords / 3));
    req_if.valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    $display("Scored %0d result words from %0d request words", checked, sent_words);
    $display("Covered hits, misses, evictions, rejects, sweeps and three stall profiles");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
